[src/ldc_pkg.sv]
package ldc_pkg;

	localparam int PWM_STEPS = 51;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_BYTE   = 2'd2;
	localparam logic [1:0] OP_IDLE   = 2'd3;

	localparam logic [7:0] CMD_VOLT       = 8'h76;
	localparam logic [7:0] CMD_DUTY_Q     = 8'h64;
	localparam logic [7:0] CMD_RES_Q      = 8'h72;
	localparam logic [7:0] CMD_UP         = 8'h77;
	localparam logic [7:0] CMD_DOWN       = 8'h6D;
	localparam logic [7:0] CMD_SET_TARGET = 8'd129;
	localparam logic [7:0] CMD_SET_DUTY   = 8'd130;
	localparam logic [7:0] CMD_CLEAR_OVR  = 8'd131;
	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;

	localparam logic [1:0] MODE_FREE = 2'd0;
	localparam logic [1:0] MODE_DUTY = 2'd1;
	localparam logic [1:0] MODE_TGT1 = 2'd2;
	localparam logic [1:0] MODE_TGT2 = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] sample;
		logic [7:0]  rx_byte;
	} in_beat_t;

	typedef struct packed {
		logic       lamp_on;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
	} out_beat_t;

endpackage

[src/led_dimmer_uart_command_controller_top.sv]
// LED dimmer with a serial command port.
// Input channel (in_valid/in_stall/in_data) carries one beat per event: a PWM
// tick, a sensor sample or a received serial byte. Output channel
// (out_valid/out_stall/out_data) returns one to six beats per input; the
// final one carries last. Beats without a reply byte have tx_valid low.
// One input is handled at a time; in_stall is high from acceptance until the
// last reply beat is loaded into the output register.
// A tick, a volt query and other byte commands go straight to emitting.
// A sample below 27200 runs a bit-serial restoring divider of 31 quotient
// steps and then a saturation step; a sample of 27200 or more saturates the
// resistance directly. Duty and resistance queries convert to decimal one
// bit per cycle by a 15-step double-dabble and a digit-load step, then send
// one beat per cycle while the output is not stalled.
// Without stalls, a sample through the divider holds the block longest.
// Reset clears the control state and settings and empties the output
// register; the datapath registers and out_data are not reset. A stalled
// output beat holds its value and the block waits.
module led_dimmer_uart_command_controller_top
	import ldc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_BCD, S_EMIT, S_DONE
	} state_t;

	state_t      state_q;
	logic [5:0]  pwm_q, duty_q;
	logic [15:0] volt_q, tgt_q;
	logic [14:0] res_q;
	logic [1:0]  mode_q;
	logic [7:0]  thigh_q;
	logic        tset_q, ovr_q, lamp_q;

	// divider: remainder, dividend/quotient shift register
	logic [15:0] rem_q, den_q;
	logic [30:0] quo_q;
	logic [4:0]  cnt_q;

	// double dabble: 5 BCD digits and binary shift
	logic [19:0] bcd_q;
	logic [14:0] bin_q;

	// reply queue of up to 6 beats
	logic [7:0]  txb_q [6];
	logic [2:0]  ntx_q, idx_q;

	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic [19:0] bcd_adj;
	logic [2:0]  ndig;
	logic        emit_go;

	assign rem_sh  = {rem_q, quo_q[30]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	always_comb begin
		if (bcd_q[19:16] != 4'd0) ndig = 3'd5;
		else if (bcd_q[15:12] != 4'd0) ndig = 3'd4;
		else if (bcd_q[11:8] != 4'd0) ndig = 3'd3;
		else if (bcd_q[7:4] != 4'd0) ndig = 3'd2;
		else ndig = 3'd1;
	end

	assign in_stall = (state_q != S_IDLE);
	assign emit_go  = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pwm_q     <= '0;
			duty_q    <= '0;
			volt_q    <= '0;
			tgt_q     <= '0;
			res_q     <= '0;
			mode_q    <= MODE_FREE;
			thigh_q   <= '0;
			tset_q    <= 1'b0;
			ovr_q     <= 1'b0;
			lamp_q    <= 1'b0;
			out_valid <= 1'b0;
			ntx_q     <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
		end else begin
			// drop a taken beat unless the emit state reloads the register
			if (out_valid && !out_stall && state_q != S_EMIT) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ntx_q   <= '0;
						idx_q   <= '0;
						state_q <= S_EMIT;
						case (in_data.op)
							OP_TICK: begin
								if (pwm_q >= 6'(PWM_STEPS)) begin
									pwm_q  <= 6'd1;
									lamp_q <= (duty_q >= 6'd1);
								end else begin
									pwm_q  <= pwm_q + 6'd1;
									lamp_q <= (pwm_q + 6'd1) <= duty_q;
								end
							end
							OP_SAMPLE: begin
								// load divider: 20000*s over 27200-s
								logic [15:0] s;
								s = in_data.sample[15] ? 16'd0 : in_data.sample;
								volt_q <= s;
								if (tset_q && !ovr_q) begin
									if (s < tgt_q && duty_q < 6'(PWM_STEPS))
										duty_q <= duty_q + 6'd1;
									else if (s > tgt_q && duty_q != 6'd0)
										duty_q <= duty_q - 6'd1;
								end
								if (s >= 16'd27200) begin
									res_q <= 15'h7FFF;
								end else begin
									quo_q   <= 31'(s) * 31'd20000;
									den_q   <= 16'd27200 - s;
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= S_DIV;
								end
							end
							OP_BYTE: begin
								unique case (mode_q)
									MODE_DUTY: begin
										duty_q <= (in_data.rx_byte > 8'(PWM_STEPS)) ?
											6'(PWM_STEPS) : in_data.rx_byte[5:0];
										ovr_q  <= 1'b1;
										mode_q <= MODE_FREE;
									end
									MODE_TGT1: begin
										thigh_q <= in_data.rx_byte;
										mode_q  <= MODE_TGT2;
									end
									MODE_TGT2: begin
										tgt_q  <= {thigh_q, in_data.rx_byte};
										tset_q <= 1'b1;
										mode_q <= MODE_FREE;
									end
									default: begin
										case (in_data.rx_byte)
											CMD_VOLT: begin
												txb_q[0] <= volt_q[15:8];
												txb_q[1] <= volt_q[7:0];
												txb_q[2] <= CHAR_CR;
												ntx_q    <= 3'd3;
											end
											CMD_DUTY_Q: begin
												bcd_q   <= '0;
												bin_q   <= {9'd0, duty_q};
												cnt_q   <= '0;
												state_q <= S_BCD;
											end
											CMD_RES_Q: begin
												bcd_q   <= '0;
												bin_q   <= res_q;
												cnt_q   <= '0;
												state_q <= S_BCD;
											end
											CMD_SET_TARGET: mode_q <= MODE_TGT1;
											CMD_SET_DUTY:   mode_q <= MODE_DUTY;
											CMD_CLEAR_OVR:  ovr_q  <= 1'b0;
											CMD_DOWN: begin
												if (duty_q != 6'd0) begin
													duty_q <= duty_q - 6'd1;
													ovr_q  <= 1'b1;
												end
											end
											CMD_UP: begin
												if (duty_q < 6'(PWM_STEPS)) begin
													duty_q <= duty_q + 6'd1;
													ovr_q  <= 1'b1;
												end
											end
											default: ;
										endcase
									end
								endcase
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					// one restoring quotient bit per cycle
					if (!rem_sub[16]) begin
						rem_q <= rem_sub[15:0];
						quo_q <= {quo_q[29:0], 1'b1};
					end else begin
						rem_q <= rem_sh[15:0];
						quo_q <= {quo_q[29:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) state_q <= S_DONE;
				end
				S_DONE: begin
					// saturate quotient into resistance
					res_q   <= (quo_q[30:15] != 16'd0) ? 15'h7FFF : quo_q[14:0];
					state_q <= S_EMIT;
				end
				S_BCD: begin
					// shift one binary bit into the BCD digits, then load the digit beats
					bcd_q <= {bcd_adj[18:0], bin_q[14]};
					bin_q <= {bin_q[13:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd14) begin
						cnt_q   <= 5'd31;
						state_q <= S_BCD;
					end
					if (cnt_q == 5'd31) begin
						bcd_q <= bcd_q;
						bin_q <= bin_q;
						for (int i = 0; i < 5; i++) begin
							if (3'(i) < ndig)
								txb_q[3'(i)] <= CHAR_ZERO + {4'd0,
									bcd_q[(32'(ndig) - 1 - i) * 4 +: 4]};
						end
						txb_q[ndig] <= CHAR_CR;
						ntx_q       <= ndig + 3'd1;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					// send queued beats, or one idle beat
					if (emit_go) begin
						out_valid        <= 1'b1;
						out_data.lamp_on <= lamp_q;
						if (ntx_q == 3'd0) begin
							out_data.tx_valid <= 1'b0;
							out_data.tx_byte  <= '0;
							out_data.last     <= 1'b1;
							state_q           <= S_IDLE;
						end else begin
							out_data.tx_valid <= 1'b1;
							out_data.tx_byte  <= txb_q[idx_q];
							out_data.last     <= (idx_q + 3'd1 == ntx_q);
							idx_q             <= idx_q + 3'd1;
							if (idx_q + 3'd1 == ntx_q) state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
